[rtl/sctk_pkg.sv]
// sctk_pkg: constants, control word layout and microcode table for the
// serial command line tokenizer. No dependencies.
`timescale 1ns / 1ps

package sctk_pkg;

  localparam int LINE_MAX = 64;
  localparam int CMD_MAX  = 16;
  localparam int TOK_MAX  = 16;
  localparam int ARGS_MAX = 8;

  // line length and store address width, token index width, kept-char count width
  localparam int LenW = $clog2(LINE_MAX);
  localparam int IdxW = 5;
  localparam int KW   = 6;

  localparam logic [LenW-1:0] LenMax  = LenW'(LINE_MAX - 1);
  localparam logic [KW-1:0]   CmdLim  = KW'(CMD_MAX - 1);
  localparam logic [KW-1:0]   TokLim  = KW'(TOK_MAX - 1);
  localparam logic [IdxW-1:0] ArgsMax = IdxW'(ARGS_MAX);

  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChDel = 8'h7F;
  localparam logic [6:0] ChSp  = 7'h20;
  localparam logic [6:0] ChTab = 7'h09;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_TEST,
    S_FETCH,
    S_EXAM,
    S_FIN
  } step_e;

  typedef enum logic [2:0] {
    OP_EDIT,
    OP_INIT,
    OP_NONE,
    OP_READ,
    OP_EXAM,
    OP_FLUSH
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_LF_LINE,
    C_POS_END,
    C_EXAM_DONE,
    C_FLUSH_DONE
  } cond_e;

  typedef struct packed {
    logic  accept;
    op_e   op;
    cond_e cond;
    step_e jmp;
    step_e nxt;
  } ctrl_t;

  typedef struct packed {
    logic lf_line;
    logic pos_end;
    logic exam_done;
    logic flush_done;
  } cond_t;

  function automatic ctrl_t sctk_rom(step_e s);
    ctrl_t w;
    case (s)
      S_IDLE:  w = '{accept: 1'b1, op: OP_EDIT,  cond: C_LF_LINE,    jmp: S_INIT, nxt: S_IDLE};
      S_INIT:  w = '{accept: 1'b0, op: OP_INIT,  cond: C_ALWAYS,     jmp: S_TEST, nxt: S_TEST};
      S_TEST:  w = '{accept: 1'b0, op: OP_NONE,  cond: C_POS_END,    jmp: S_FIN,  nxt: S_FETCH};
      S_FETCH: w = '{accept: 1'b0, op: OP_READ,  cond: C_ALWAYS,     jmp: S_EXAM, nxt: S_EXAM};
      S_EXAM:  w = '{accept: 1'b0, op: OP_EXAM,  cond: C_EXAM_DONE,  jmp: S_TEST, nxt: S_EXAM};
      S_FIN:   w = '{accept: 1'b0, op: OP_FLUSH, cond: C_FLUSH_DONE, jmp: S_IDLE, nxt: S_FIN};
      default: w = '{accept: 1'b0, op: OP_NONE,  cond: C_ALWAYS,     jmp: S_IDLE, nxt: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/sctk_seq.sv]
// sctk_seq: step counter and microcode table lookup with conditional jumps.
// Depends on sctk_pkg.
`timescale 1ns / 1ps

module sctk_seq import sctk_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cond_t cond_i,
  output ctrl_t ctrl_o
);

  step_e step_q, step_d;
  logic  taken;

  assign ctrl_o = sctk_rom(step_q);

  always_comb begin
    case (ctrl_o.cond)
      C_ALWAYS:     taken = 1'b1;
      C_LF_LINE:    taken = cond_i.lf_line;
      C_POS_END:    taken = cond_i.pos_end;
      C_EXAM_DONE:  taken = cond_i.exam_done;
      C_FLUSH_DONE: taken = cond_i.flush_done;
      default:      taken = 1'b1;
    endcase
    step_d = taken ? ctrl_o.jmp : ctrl_o.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

[rtl/serial_command_line_tokenizer.sv]
// Edits received bytes into a line store; on line feed walks the store and
// emits kept token characters through a pending stage and an output register.
// Steps: edit bytes are taken while idle; after a line feed the sequencer runs
// INIT, then TEST, FETCH and EXAM for each stored character (LINE_MAX-1 at
// most), where EXAM may wait while the output stalls, then FIN flushes the
// pending character. Reset empties the line; the store itself is not cleared.
`timescale 1ns / 1ps

module serial_command_line_tokenizer import sctk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       token_valid_o,
  input  logic       token_ready_i,
  output logic [3:0] token_index_o,
  output logic [6:0] token_char_o,
  output logic       token_end_o,
  output logic       line_end_o
);

  ctrl_t ctrl;
  cond_t cond;

  logic [6:0] mem [LINE_MAX];
  logic [6:0] rdata_q;

  logic [LenW-1:0] len_q, len_d, pos_q, pos_d;
  logic [KW-1:0]   k_q, k_d, lim_q, lim_d;
  logic [IdxW-1:0] args_q, args_d, idx_q, idx_d;
  logic            have_cmd_q, have_cmd_d, in_tok_q, in_tok_d, keep_q, keep_d;
  logic            pend_v_q, pend_v_d, out_v_q, out_v_d;

  logic [IdxW-1:0] pend_idx_q, pend_idx_d, out_idx_q;
  logic [6:0]      pend_char_q, pend_char_d, out_char_q;
  logic            pend_end_q, pend_end_d, out_end_q, out_line_q;

  logic            mem_we, rd_en, sep, emit, out_free;
  logic            new_keep, exam_done, flush_done;
  logic [IdxW-1:0] new_idx;
  logic [KW-1:0]   new_lim;
  logic            push, push_end, push_line;

  sctk_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  assign rx_ready_o    = ctrl.accept;
  assign token_valid_o = out_v_q;
  assign token_index_o = out_idx_q[3:0];
  assign token_char_o  = out_char_q;
  assign token_end_o   = out_end_q;
  assign line_end_o    = out_line_q;

  assign out_free = !out_v_q || token_ready_i;
  assign sep      = (rdata_q == ChSp) || (rdata_q == ChTab);

  // classification of a token that starts here
  always_comb begin
    new_keep = 1'b0;
    new_idx  = '0;
    new_lim  = CmdLim;
    if (!have_cmd_q) begin
      new_keep = 1'b1;
    end else if (args_q < ArgsMax) begin
      new_keep = 1'b1;
      new_idx  = args_q + IdxW'(1);
      new_lim  = TokLim;
    end
  end

  assign emit       = !sep && (in_tok_q ? (keep_q && (k_q < lim_q)) : new_keep);
  assign exam_done  = !(emit && pend_v_q) || out_free;
  assign flush_done = !pend_v_q || out_free;

  assign cond.lf_line    = rx_valid_i && (rx_byte_i == ChLf) && (len_q != '0);
  assign cond.pos_end    = (pos_q == len_q);
  assign cond.exam_done  = exam_done;
  assign cond.flush_done = flush_done;

  always_comb begin
    len_d       = len_q;
    pos_d       = pos_q;
    k_d         = k_q;
    lim_d       = lim_q;
    args_d      = args_q;
    idx_d       = idx_q;
    have_cmd_d  = have_cmd_q;
    in_tok_d    = in_tok_q;
    keep_d      = keep_q;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    pend_char_d = pend_char_q;
    pend_end_d  = pend_end_q;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    push        = 1'b0;
    push_end    = pend_end_q;
    push_line   = 1'b0;
    case (ctrl.op)
      OP_EDIT: begin
        if (rx_valid_i) begin
          if ((rx_byte_i == ChBs) || (rx_byte_i == ChDel)) begin
            if (len_q != '0) begin
              len_d = len_q - LenW'(1);
            end
          end else if (rx_byte_i inside {[8'h20:8'h7E]}) begin
            if (len_q < LenMax) begin
              mem_we = 1'b1;
              len_d  = len_q + LenW'(1);
            end
          end
        end
      end
      OP_INIT: begin
        pos_d      = '0;
        in_tok_d   = 1'b0;
        have_cmd_d = 1'b0;
        args_d     = '0;
        pend_v_d   = 1'b0;
      end
      OP_READ: begin
        rd_en = 1'b1;
      end
      OP_EXAM: begin
        if (exam_done) begin
          pos_d = pos_q + LenW'(1);
          if (sep) begin
            in_tok_d = 1'b0;
            if (in_tok_q && keep_q) begin
              pend_end_d = 1'b1;
            end
          end else begin
            if (!in_tok_q) begin
              in_tok_d = 1'b1;
              keep_d   = new_keep;
              idx_d    = new_idx;
              lim_d    = new_lim;
              k_d      = '0;
              if (!have_cmd_q) begin
                have_cmd_d = 1'b1;
              end else if (new_keep) begin
                args_d = new_idx;
              end
            end
            if (emit) begin
              push        = pend_v_q;
              pend_v_d    = 1'b1;
              pend_idx_d  = in_tok_q ? idx_q : new_idx;
              pend_char_d = rdata_q;
              pend_end_d  = 1'b0;
              k_d         = in_tok_q ? (k_q + KW'(1)) : KW'(1);
            end
          end
        end
      end
      OP_FLUSH: begin
        if (flush_done) begin
          len_d = '0;
          if (pend_v_q) begin
            push      = 1'b1;
            push_end  = pend_end_q || (in_tok_q && keep_q);
            push_line = 1'b1;
            pend_v_d  = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (push) begin
      out_v_d = 1'b1;
    end else if (token_ready_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  // line store: one write port for editing, one registered read for the scan
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[len_q] <= rx_byte_i[6:0];
    end
    if (rd_en) begin
      rdata_q <= mem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    pend_char_q <= pend_char_d;
    pend_end_q  <= pend_end_d;
    idx_q       <= idx_d;
    lim_q       <= lim_d;
    k_q         <= k_d;
    pos_q       <= pos_d;
    if (push) begin
      out_idx_q  <= pend_idx_q;
      out_char_q <= pend_char_q;
      out_end_q  <= push_end;
      out_line_q <= push_line;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      args_q     <= '0;
      have_cmd_q <= 1'b0;
      in_tok_q   <= 1'b0;
      keep_q     <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      len_q      <= len_d;
      args_q     <= args_d;
      have_cmd_q <= have_cmd_d;
      in_tok_q   <= in_tok_d;
      keep_q     <= keep_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
    end
  end

  // no held character may be left behind when new bytes are taken
  a_idle_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_ready_o |-> !pend_v_q)
    else $error("pending item while accepting input");

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax)
    else $error("line length beyond limit");

  a_scan_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_EXAM || ctrl.op == OP_READ) |-> (pos_q < len_q))
    else $error("scan position past line end");

  a_line_end_tok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (token_valid_o && line_end_o) |-> token_end_o)
    else $error("line end without token end");

  a_push_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("output register overwritten");

endmodule
